[hdl/sawbc_pkg.sv]
// Package for the set-associative write-back cache tag store.
// Holds the geometry constants, the line record and the register indexes.
// No dependencies.
package sawbc_pkg;

	localparam int SET_INDEX_MAX_BITS = 6;
	localparam int WAYS               = 4;
	localparam int ADDR_WIDTH         = 64;
	localparam int STAMP_WIDTH        = 32;
	localparam int CNT_WIDTH          = 32;

	localparam int NUM_SETS  = 1 << SET_INDEX_MAX_BITS;
	localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int SIB_W     = 3;
	localparam int BOFF_W    = 4;
	localparam int WCNT_W    = 3;
	localparam int SHAMT_W   = 5;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 4;
	localparam int OUT_BITS  = 3 + ADDR_WIDTH + 4 * CNT_WIDTH;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX_BITS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_OFFSET_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE       = 2'd2;

	localparam logic [SIB_W-1:0]  SIB_RESET  = 3'd6;
	localparam logic [BOFF_W-1:0] BOFF_RESET = 4'd6;
	localparam logic [WCNT_W-1:0] WAYS_RESET = 3'd4;

	typedef struct packed {
		logic                   dirty;
		logic [ADDR_WIDTH-1:0]  tag;
		logic [STAMP_WIDTH-1:0] stamp;
	} line_t;

	typedef line_t [WAYS-1:0] set_row_t;

endpackage

[hdl/set_assoc_lru_writeback_cache_tags_top.sv]
// Tag store of a set-associative write-back cache with LRU replacement.
// Single module: line memory, valid bits, lookup and replacement, counters.
// Depends on sawbc_pkg.

// For each request, in the accept cycle the set's row (dirty, tag
// and stamp of every way) is read from a single-port synchronous memory; in the
// next cycle the tags and stamps are compared, the chosen way is written back
// and the result is loaded into the output register. The block takes no new
// request until the lookup is done and the output register is empty or being
// read. Valid bits live in flip-flops cleared by reset, so no clearing pass is
// needed and requests are taken right after reset. Configuration writes must
// only happen while no request is in flight.
module set_assoc_lru_writeback_cache_tags_top
	import sawbc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [ADDR_WIDTH-1:0] s_axis_tdata,   // address
	input  logic [0:0]            s_axis_tuser,   // req_type
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// hit, evicted, evicted_dirty, evicted_tag, hit_total, miss_total,
	// dirty_evictions, clean_evictions, zero pad
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	typedef enum logic {ST_IDLE, ST_LOOKUP} state_t;

	state_t state_q;

	logic [SIB_W-1:0]  cfg_sib_q;
	logic [BOFF_W-1:0] cfg_boff_q;
	logic [WCNT_W-1:0] cfg_ways_q;

	set_row_t line_mem [NUM_SETS];
	set_row_t rd_row_s1;
	logic [WAYS-1:0] valid_q [NUM_SETS];

	logic [ADDR_WIDTH-1:0]         tag_s1;
	logic [SET_INDEX_MAX_BITS-1:0] set_s1;
	logic                          wr_s1;

	logic [CNT_WIDTH-1:0] hit_cnt_q, miss_cnt_q, dirty_cnt_q, clean_cnt_q;

	logic                  out_valid_q;
	logic                  out_hit_q, out_ev_q, out_evd_q;
	logic [ADDR_WIDTH-1:0] out_evtag_q;

	logic                          in_acc;
	logic [SIB_W-1:0]              sib_eff;
	logic [WCNT_W-1:0]             ways_eff;
	logic [SHAMT_W-1:0]            tag_shamt;
	logic [ADDR_WIDTH-1:0]         addr_sh;
	logic [SET_INDEX_MAX_BITS-1:0] set_mask, set_in;
	logic [ADDR_WIDTH-1:0]         tag_in;

	logic [WAYS-1:0]        way_used, set_valid;
	logic                   hit_found, free_found, evict;
	logic [WAY_W-1:0]       hit_way, free_way, vict_way, sel_way;
	logic [STAMP_WIDTH-1:0] min_stamp, new_stamp;
	logic [CNT_WIDTH-1:0]   hit_nx, miss_nx, dirty_nx, clean_nx;
	logic [CNT_WIDTH:0]     stamp_sum;
	set_row_t               wr_row;

	function automatic logic [CNT_WIDTH-1:0] sat_inc(input logic [CNT_WIDTH-1:0] v);
		return (v == {CNT_WIDTH{1'b1}}) ? v : v + 1'b1;
	endfunction

	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
	assign m_axis_tvalid = out_valid_q;

	// Address split for the incoming request
	always_comb begin
		sib_eff   = (cfg_sib_q > SIB_W'(SET_INDEX_MAX_BITS)) ?
			SIB_W'(SET_INDEX_MAX_BITS) : cfg_sib_q;
		tag_shamt = SHAMT_W'(sib_eff) + SHAMT_W'(cfg_boff_q);
		addr_sh   = s_axis_tdata >> cfg_boff_q;
		set_mask  = ~({SET_INDEX_MAX_BITS{1'b1}} << sib_eff);
		set_in    = addr_sh[SET_INDEX_MAX_BITS-1:0] & set_mask;
		tag_in    = s_axis_tdata >> tag_shamt;
	end

	always_comb begin
		if (cfg_ways_q == '0)
			ways_eff = WCNT_W'(1);
		else if (cfg_ways_q > WCNT_W'(WAYS))
			ways_eff = WCNT_W'(WAYS);
		else
			ways_eff = cfg_ways_q;
	end

	// Lookup and replacement choice over the ways of the set that was read
	always_comb begin
		set_valid  = valid_q[set_s1];
		hit_found  = 1'b0;
		free_found = 1'b0;
		hit_way    = '0;
		free_way   = '0;
		vict_way   = '0;
		min_stamp  = rd_row_s1[0].stamp;
		for (int w = 0; w < WAYS; w++) begin
			way_used[w] = WCNT_W'(w) < ways_eff;
			if (way_used[w] && set_valid[w] && rd_row_s1[w].tag == tag_s1 && !hit_found) begin
				hit_found = 1'b1;
				hit_way   = WAY_W'(w);
			end
			if (way_used[w] && !set_valid[w] && !free_found) begin
				free_found = 1'b1;
				free_way   = WAY_W'(w);
			end
			// strict compare keeps the lowest way among equal stamps
			if (way_used[w] && set_valid[w] && rd_row_s1[w].stamp < min_stamp) begin
				min_stamp = rd_row_s1[w].stamp;
				vict_way  = WAY_W'(w);
			end
		end
		evict   = !hit_found && !free_found;
		sel_way = hit_found ? hit_way : (free_found ? free_way : vict_way);

		hit_nx   = hit_found ? sat_inc(hit_cnt_q) : hit_cnt_q;
		miss_nx  = hit_found ? miss_cnt_q : sat_inc(miss_cnt_q);
		dirty_nx = (evict && rd_row_s1[vict_way].dirty) ? sat_inc(dirty_cnt_q) : dirty_cnt_q;
		clean_nx = (evict && !rd_row_s1[vict_way].dirty) ? sat_inc(clean_cnt_q) : clean_cnt_q;
		stamp_sum = {1'b0, hit_nx} + {1'b0, miss_nx};
		new_stamp = stamp_sum[STAMP_WIDTH-1:0];

		wr_row = rd_row_s1;
		if (hit_found) begin
			wr_row[sel_way].dirty = rd_row_s1[sel_way].dirty | wr_s1;
			wr_row[sel_way].stamp = new_stamp;
		end else begin
			wr_row[sel_way].dirty = wr_s1;
			wr_row[sel_way].tag   = tag_s1;
			wr_row[sel_way].stamp = new_stamp;
		end
	end

	// Line memory: read on accept, write back the updated row in the lookup cycle
	always_ff @(posedge clk) begin
		if (in_acc)
			rd_row_s1 <= line_mem[set_in];
		if (state_q == ST_LOOKUP)
			line_mem[set_s1] <= wr_row;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			tag_s1 <= tag_in;
			set_s1 <= set_in;
			wr_s1  <= s_axis_tuser[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_sib_q  <= SIB_RESET;
			cfg_boff_q <= BOFF_RESET;
			cfg_ways_q <= WAYS_RESET;
		end else if (cfg_wen) begin
			case (cfg_idx)
				CFG_SET_INDEX_BITS:    cfg_sib_q  <= cfg_wdata[SIB_W-1:0];
				CFG_BLOCK_OFFSET_BITS: cfg_boff_q <= cfg_wdata[BOFF_W-1:0];
				CFG_WAYS_IN_USE:       cfg_ways_q <= cfg_wdata[WCNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			dirty_cnt_q <= '0;
			clean_cnt_q <= '0;
			valid_q     <= '{default: '0};
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (out_valid_q && m_axis_tready)
						out_valid_q <= 1'b0;
					if (in_acc)
						state_q <= ST_LOOKUP;
				end
				ST_LOOKUP: begin
					out_valid_q <= 1'b1;
					hit_cnt_q   <= hit_nx;
					miss_cnt_q  <= miss_nx;
					dirty_cnt_q <= dirty_nx;
					clean_cnt_q <= clean_nx;
					valid_q[set_s1][sel_way] <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result payload; counters only move in the lookup cycle, so they hold with it
	always_ff @(posedge clk) begin
		if (state_q == ST_LOOKUP) begin
			out_hit_q   <= hit_found;
			out_ev_q    <= evict;
			out_evd_q   <= evict && rd_row_s1[vict_way].dirty;
			out_evtag_q <= evict ? rd_row_s1[vict_way].tag : '0;
		end
	end

	assign m_axis_tdata = {{(OUT_DATA_W - OUT_BITS){1'b0}}, clean_cnt_q, dirty_cnt_q,
		miss_cnt_q, hit_cnt_q, out_evtag_q, out_evd_q, out_ev_q, out_hit_q};

`ifndef ASSERT_OFF
	a_lookup_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOKUP) |-> !out_valid_q)
		else $error("lookup finished while previous result still pending");

	a_lookup_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOKUP) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("result not presented after lookup");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_hit_q) |-> (!out_ev_q && !out_evd_q && out_evtag_q == '0))
		else $error("hit result carries eviction data");

	a_accept_starts_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_LOOKUP && !s_axis_tready))
		else $error("accepted request did not start a lookup");
`endif

endmodule
